>>> design/kct_pkg.sv
`default_nettype none

package kct_pkg;

  localparam int KEY_W = 32;
  localparam int CNT_W = 32;
  localparam int LIMIT_W = 7;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  // Request codes as they arrive on the input channel
  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_PEEK   = 2'd3
  } req_code_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2,
    ST_SHORT   = 2'd3
  } status_t;

  // Operation class handed from the front to the back
  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_SUB  = 2'd1,
    OP_READ = 2'd2
  } op_t;

  typedef struct packed {
    op_t              op;
    logic             stock_test;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] amt;
  } cmd_t;

  typedef struct packed {
    status_t          status;
    logic             key_found;
    logic [CNT_W-1:0] held_count;
    logic             in_stock;
  } rsp_t;

endpackage

`default_nettype wire

>>> design/kct_if.sv
`default_nettype none

interface kct_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] item_key;
  logic [31:0] amount;

  modport source (output valid, output req_type, output item_key, output amount,
                  input ready);
  modport sink (input valid, input req_type, input item_key, input amount,
                output ready);
endinterface

interface kct_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        key_found;
  logic [31:0] held_count;
  logic        in_stock;

  modport source (output valid, output status, output key_found, output held_count,
                  output in_stock, input ready);
  modport sink (input valid, input status, input key_found, input held_count,
                input in_stock, output ready);
endinterface

`default_nettype wire

>>> design/kct_front.sv
`default_nettype none

module kct_front (
  input  wire logic   clk,
  input  wire logic   rst,
  kct_req_if.sink     req,
  output logic        out_valid,
  input  wire logic   out_ready,
  output kct_pkg::cmd_t out_cmd
);
  import kct_pkg::*;

  logic hold_valid;
  cmd_t hold_cmd;
  cmd_t dec_cmd;
  logic take;

  assign req.ready = !hold_valid || out_ready;
  assign take      = req.valid && req.ready;

  // Classify the request; a peek reads like a query with no stock test
  always_comb begin
    dec_cmd.key        = req.item_key;
    dec_cmd.amt        = req.amount;
    dec_cmd.op         = OP_READ;
    dec_cmd.stock_test = 1'b0;
    unique case (req_code_t'(req.req_type))
      REQ_ADD:    dec_cmd.op = OP_ADD;
      REQ_REMOVE: dec_cmd.op = OP_SUB;
      REQ_QUERY:  dec_cmd.stock_test = 1'b1;
      REQ_PEEK:   dec_cmd.stock_test = 1'b0;
      default:    dec_cmd.op = OP_READ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take) begin
      hold_valid <= 1'b1;
    end else if (out_ready) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_cmd <= dec_cmd;
    end
  end

  assign out_valid = hold_valid;
  assign out_cmd   = hold_cmd;

endmodule

`default_nettype wire

>>> design/kct_fifo.sv
`default_nettype none

module kct_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire kct_pkg::cmd_t in_cmd,
  output logic               out_valid,
  input  wire logic          out_ready,
  output kct_pkg::cmd_t      out_cmd
);
  import kct_pkg::*;

  localparam int DEPTH = 2;
  localparam int PW = $clog2(DEPTH);

  cmd_t slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   fill;
  logic push;
  logic pop;

  assign in_ready  = fill != (PW+1)'(DEPTH);
  assign out_valid = fill != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_cmd;
    end
  end

endmodule

`default_nettype wire

>>> design/kct_back.sv
`default_nettype none

module kct_back #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic [kct_pkg::LIMIT_W-1:0] entry_limit,
  input  wire logic                    cmd_valid,
  output logic                         cmd_ready,
  input  wire kct_pkg::cmd_t           cmd_in,
  output logic                         rsp_valid,
  input  wire logic                    rsp_ready,
  output kct_pkg::rsp_t                rsp_out
);
  import kct_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_DECIDE = 3'b100
  } state_t;

  logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
  logic [CNT_W-1:0] cnt_mem [TABLE_DEPTH];

  state_t state;
  cmd_t   cmd;
  logic [CW-1:0] issue_idx;
  logic          pend;
  logic [IW-1:0] pend_idx;
  logic          found;
  logic [IW-1:0] slot;
  logic [CW-1:0] used;
  logic [KEY_W-1:0] key_rd;
  logic [CNT_W-1:0] cnt_rd;
  rsp_t res;
  logic res_valid;

  logic issue_go;
  logic match;
  logic last_seen;
  logic advance;
  logic [CW-1:0] used_last;
  logic [LW-1:0] limit_eff;
  logic          table_full;
  logic [CNT_W:0] sum;
  rsp_t res_next;
  logic key_we;
  logic cnt_we;
  logic [IW-1:0] wr_addr;
  logic [CNT_W-1:0] cnt_wdata;
  logic used_inc;

  assign cmd_ready = state == S_IDLE;
  assign issue_go  = (state == S_SEARCH) && (issue_idx < used);
  assign match     = pend && (key_rd == cmd.key);
  assign used_last = used - 1'b1;
  assign last_seen = pend && (CW'(pend_idx) == used_last);
  assign advance   = (state == S_DECIDE) && (!res_valid || rsp_ready);

  // Clamp the limit to the table depth
  assign limit_eff = (LW'(entry_limit) > LW'(TABLE_DEPTH)) ? LW'(TABLE_DEPTH)
                                                          : LW'(entry_limit);
  assign table_full = LW'(used) >= limit_eff;
  assign sum = {1'b0, cnt_rd} + {1'b0, cmd.amt};

  always_comb begin
    res_next.status     = ST_OK;
    res_next.key_found  = found;
    res_next.held_count = '0;
    res_next.in_stock   = 1'b0;
    key_we    = 1'b0;
    cnt_we    = 1'b0;
    wr_addr   = slot;
    cnt_wdata = '0;
    used_inc  = 1'b0;
    unique case (cmd.op)
      OP_ADD: begin
        if (found) begin
          cnt_we    = 1'b1;
          cnt_wdata = sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
          res_next.held_count = cnt_wdata;
        end else if (table_full) begin
          res_next.status = ST_FULL;
        end else begin
          key_we    = 1'b1;
          cnt_we    = 1'b1;
          wr_addr   = used[IW-1:0];
          cnt_wdata = cmd.amt;
          used_inc  = 1'b1;
          res_next.held_count = cmd.amt;
        end
      end
      OP_SUB: begin
        if (!found) begin
          res_next.status = ST_MISSING;
        end else if (cnt_rd >= cmd.amt) begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_rd - cmd.amt;
          res_next.held_count = cnt_wdata;
        end else begin
          cnt_we = 1'b1;
          res_next.status = ST_SHORT;
        end
      end
      OP_READ: begin
        if (!found) begin
          res_next.status = ST_MISSING;
        end else begin
          res_next.held_count = cnt_rd;
          res_next.in_stock   = cmd.stock_test && (cnt_rd >= cmd.amt);
        end
      end
      default: begin
        res_next.status = ST_MISSING;
      end
    endcase
  end

  // Sequencer: scan keys one per cycle, then update the count where the command changes it
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      pend      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (advance) begin
        res_valid <= 1'b1;
      end else if (rsp_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          pend <= 1'b0;
          if (cmd_valid) begin
            state <= (used == '0) ? S_DECIDE : S_SEARCH;
          end
        end
        S_SEARCH: begin
          pend <= issue_go;
          if (match || last_seen) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (advance) begin
            state <= S_IDLE;
            if (used_inc) begin
              used <= used + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd_valid) begin
      cmd       <= cmd_in;
      issue_idx <= '0;
      found     <= 1'b0;
    end
    if (state == S_SEARCH) begin
      pend_idx <= issue_idx[IW-1:0];
      if (issue_go) begin
        issue_idx <= issue_idx + 1'b1;
      end
      if (match) begin
        found <= 1'b1;
        slot  <= pend_idx;
      end
    end
    if (advance) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (issue_go) begin
      key_rd <= key_mem[issue_idx[IW-1:0]];
    end
    if (key_we && advance) begin
      key_mem[wr_addr] <= cmd.key;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SEARCH && match) begin
      cnt_rd <= cnt_mem[pend_idx];
    end
    if (cnt_we && advance) begin
      cnt_mem[wr_addr] <= cnt_wdata;
    end
  end

  assign rsp_valid = res_valid;
  assign rsp_out   = res;

endmodule

`default_nettype wire

>>> design/keyed_count_table_top.sv
// Keyed count table: a store of key and count pairs searched by key.
// Request channel (req): req_type (0 add, 1 remove, 2 query, 3 read without
// stock test), item_key and amount; a transaction is taken when valid and
// ready are both high. Response channel (rsp): one transaction per request,
// in order, carrying status, key_found, held_count and in_stock.
// Configuration: cfg_we writes cfg_wdata into entry_limit at the clock edge.
// The front decodes a request into a register and a two-deep queue holds
// commands for the back, so requests keep flowing while the back is busy.
// The back scans stored keys one per cycle from its key memory, first match
// wins, then reads the count on a match and writes it at most once. The back
// takes one item at a time; its time per item grows with used (entries held,
// at most TABLE_DEPTH), as the key scan may visit every held entry.
// Reset clears the entry count, the queue and the response valid flag and sets
// entry_limit to 64; memory contents need no clearing.
// When the receiver stalls, the response register holds its transaction;
// the back searches the next item and waits to write it, then the queue and front fill
// and req.ready falls.
`default_nettype none

module keyed_count_table_top #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [kct_pkg::LIMIT_W-1:0] cfg_wdata,
  kct_req_if.sink                          req,
  kct_rsp_if.source                        rsp
);
  import kct_pkg::*;

  logic [LIMIT_W-1:0] entry_limit;

  logic front_valid;
  logic front_ready;
  cmd_t front_cmd;
  logic queue_valid;
  logic queue_ready;
  cmd_t queue_cmd;
  rsp_t back_rsp;

  // Hold the limit until rewritten
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      entry_limit <= cfg_wdata;
    end
  end

  kct_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_cmd   (front_cmd)
  );

  kct_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_cmd    (front_cmd),
    .out_valid (queue_valid),
    .out_ready (queue_ready),
    .out_cmd   (queue_cmd)
  );

  kct_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .entry_limit (entry_limit),
    .cmd_valid   (queue_valid),
    .cmd_ready   (queue_ready),
    .cmd_in      (queue_cmd),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_out     (back_rsp)
  );

  // Drive the response payload from the back's result register
  assign rsp.status     = back_rsp.status;
  assign rsp.key_found  = back_rsp.key_found;
  assign rsp.held_count = back_rsp.held_count;
  assign rsp.in_stock   = back_rsp.in_stock;

`ifndef SYNTHESIS
  // Any failing status carries no count and no stock flag
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != ST_OK) |-> (rsp.held_count == '0 && !rsp.in_stock))
    else $error("failing status with nonzero count");

  // Stock can only be reported for a present key with ok status
  a_stock_found: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.in_stock) |-> (rsp.key_found && rsp.status == ST_OK))
    else $error("in_stock without a found key");

  // Full and not found only arise for an absent key, shortfall for a present one
  a_found_status: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status == ST_FULL || rsp.status == ST_MISSING)) |-> !rsp.key_found)
    else $error("absent-key status with key_found set");

  a_short_found: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_SHORT) |-> rsp.key_found)
    else $error("shortfall reported for an absent key");
`endif

endmodule

`default_nettype wire

>>> tb/keyed_count_table_ledger.sv
`timescale 1ns / 1ps

module keyed_count_table_ledger #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [kct_pkg::LIMIT_W-1:0] cfg_wdata,
  input  logic                        req_valid,
  input  logic                        req_ready,
  input  logic [1:0]                  req_type,
  input  logic [31:0]                 item_key,
  input  logic [31:0]                 amount,
  input  logic                        rsp_valid,
  input  logic                        rsp_ready,
  input  logic [1:0]                  status,
  input  logic                        key_found,
  input  logic [31:0]                 held_count,
  input  logic                        in_stock,
  output int unsigned                 outstanding,
  output int unsigned                 mismatches
);
  import kct_pkg::*;

  logic [KEY_W-1:0]   shadow_keys [TABLE_DEPTH];
  logic [CNT_W-1:0]   shadow_counts [TABLE_DEPTH];
  int unsigned        shadow_used;
  logic [LIMIT_W-1:0] shadow_limit;
  rsp_t               due_replies[$];

  // Apply one request to the shadow table and return the reply it must give.
  function automatic rsp_t book_request(input req_code_t code, input logic [KEY_W-1:0] key,
                                        input logic [CNT_W-1:0] amt);
    rsp_t        reply;
    int          slot;
    int unsigned cap;
    reply = '0;
    reply.status = ST_OK;
    slot = -1;
    for (int i = 0; i < shadow_used; i++) begin
      if (slot < 0 && shadow_keys[i] == key) slot = i;
    end
    cap = (shadow_limit > TABLE_DEPTH) ? TABLE_DEPTH : 32'(shadow_limit);
    reply.key_found = (slot >= 0);
    case (code)
      REQ_ADD: begin
        if (slot >= 0) begin
          // saturate rather than wrap
          shadow_counts[slot] = (amt > ~shadow_counts[slot]) ? '1 : shadow_counts[slot] + amt;
          reply.held_count = shadow_counts[slot];
        end else if (shadow_used >= cap) begin
          reply.status = ST_FULL;
        end else begin
          shadow_keys[shadow_used] = key;
          shadow_counts[shadow_used] = amt;
          shadow_used++;
          reply.held_count = amt;
        end
      end
      REQ_REMOVE: begin
        if (slot < 0) begin
          reply.status = ST_MISSING;
        end else if (shadow_counts[slot] >= amt) begin
          shadow_counts[slot] = shadow_counts[slot] - amt;
          reply.held_count = shadow_counts[slot];
        end else begin
          shadow_counts[slot] = '0;
          reply.status = ST_SHORT;
        end
      end
      default: begin
        if (slot < 0) begin
          reply.status = ST_MISSING;
        end else begin
          reply.held_count = shadow_counts[slot];
          reply.in_stock = (code == REQ_QUERY) && (shadow_counts[slot] >= amt);
        end
      end
    endcase
    return reply;
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      shadow_used = 0;
      shadow_limit = LIMIT_RESET;
      due_replies.delete();
    end else begin
      if (cfg_we) shadow_limit = cfg_wdata;
      if (rsp_valid && rsp_ready) begin
        if (due_replies.size() == 0) begin
          $error("response transaction with nothing expected");
          mismatches++;
        end else begin
          want = due_replies.pop_front();
          compare_field("status", 32'(want.status), 32'(status));
          compare_field("key_found", 32'(want.key_found), 32'(key_found));
          compare_field("held_count", want.held_count, held_count);
          compare_field("in_stock", 32'(want.in_stock), 32'(in_stock));
        end
      end
      if (req_valid && req_ready)
        due_replies.push_back(book_request(req_code_t'(req_type), item_key, amount));
    end
    outstanding = due_replies.size();
  end

endmodule

>>> tb/keyed_count_table_top_tb.sv
`timescale 1ns / 1ps

module keyed_count_table_top_tb;
  import kct_pkg::*;

  localparam int          TABLE_DEPTH     = 64;
  localparam int          KEY_POOL        = 96;
  localparam int          HOLD_OFF_CYCLES = 400;
  // a full table scan plus the front and the response register
  localparam int          DRAIN_CYCLES    = TABLE_DEPTH + 16;
  // roughly 1000 transactions, with the allowance per transaction taken several times over
  localparam int unsigned CYCLE_LIMIT     = 600000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata = '0;

  int unsigned outstanding;
  int unsigned mismatches;
  int unsigned cycles = 0;

  // idling switches for each side, and the one-off long receiver hold-off
  bit send_idle = 1'b1;
  bit take_idle = 1'b1;
  bit hold_off_ask = 1'b0;
  bit hold_off_done = 1'b0;

  logic [31:0] key_pool [KEY_POOL];

  kct_req_if req ();
  kct_rsp_if rsp ();

  keyed_count_table_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .rsp       (rsp)
  );

  // Watch both channels, predict each response and compare it.
  keyed_count_table_ledger #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) ledger (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .req_type    (req.req_type),
    .item_key    (req.item_key),
    .amount      (req.amount),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .status      (rsp.status),
    .key_found   (rsp.key_found),
    .held_count  (rsp.held_count),
    .in_stock    (rsp.in_stock),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  always #5 clk = ~clk;

  // Guard against a hang: end the run if the cycle count runs away.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("keyed_count_table_top_tb: FAIL");
      $finish;
    end
  end

  // Receiver: decide ready once per falling edge. On request, hold off for a
  // long stretch so the block fills up and drops req.ready.
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_ask && !hold_off_done) begin
        rsp.ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_done = 1'b1;
      end
      rsp.ready = take_idle ? ($urandom_range(99) >= 35) : 1'b1;
    end
  end

  // Offer one request transaction and hold it until it is taken. Called and
  // left at a falling edge; valid stays high if the next call offers at once.
  task automatic send_request(input req_code_t code, input logic [31:0] key,
                              input logic [31:0] amt);
    while (send_idle && $urandom_range(99) < 35) begin
      req.valid = 1'b0;
      @(negedge clk);
    end
    req.valid = 1'b1;
    req.req_type = code;
    req.item_key = key;
    req.amount = amt;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
  endtask

  // Drop valid and wait for every outstanding response to come back.
  task automatic wait_drained();
    req.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Write entry_limit; only ever called with the block drained.
  task automatic write_limit(input logic [LIMIT_W-1:0] limit);
    cfg_we = 1'b1;
    cfg_wdata = limit;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // One random phase: set the limit, then send a mix of requests whose keys
  // mostly come from the first span entries of the pool so that they hit.
  task automatic run_phase(input logic [LIMIT_W-1:0] limit, input int items, input int span);
    req_code_t   code;
    logic [31:0] key;
    logic [31:0] amt;
    int          pick;
    wait_drained();
    write_limit(limit);
    for (int n = 0; n < items; n++) begin
      pick = $urandom_range(99);
      if (pick < 40) code = REQ_ADD;
      else if (pick < 65) code = REQ_REMOVE;
      else if (pick < 90) code = REQ_QUERY;
      else code = REQ_PEEK;
      key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(span - 1)] : $urandom;
      pick = $urandom_range(9);
      if (pick == 0) amt = '0;
      else if (pick == 1) amt = '1;
      else if (pick < 4) amt = $urandom;
      else amt = $urandom_range(200);
      send_request(code, key, amt);
    end
  endtask

  initial begin
    // drive every input to a known value from time zero
    req.valid = 1'b0;
    req.req_type = REQ_ADD;
    req.item_key = '0;
    req.amount = '0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Limit zero: every insert reports full, everything else finds nothing.
    write_limit(7'd0);
    send_request(REQ_ADD, key_pool[0], 32'd5);
    send_request(REQ_QUERY, key_pool[0], 32'd0);
    send_request(REQ_REMOVE, key_pool[0], 32'd1);
    send_request(REQ_PEEK, key_pool[0], 32'd0);

    // Limit above the depth: acts as the depth. Walk the count edge cases.
    wait_drained();
    write_limit(7'd127);
    send_request(REQ_ADD, key_pool[0], 32'hFFFF_FFFF);
    send_request(REQ_ADD, key_pool[0], 32'd1);            // saturates
    send_request(REQ_QUERY, key_pool[0], 32'hFFFF_FFFF);  // covered
    send_request(REQ_ADD, key_pool[1], 32'd0);
    send_request(REQ_QUERY, key_pool[1], 32'd1);          // not covered
    send_request(REQ_PEEK, key_pool[1], 32'd0);           // no stock flag
    send_request(REQ_REMOVE, key_pool[0], 32'hFFFF_FFFE);
    send_request(REQ_REMOVE, key_pool[0], 32'd2);         // shortfall
    send_request(REQ_QUERY, key_pool[0], 32'd0);
    send_request(REQ_ADD, key_pool[2], 32'd100);
    send_request(REQ_REMOVE, key_pool[2], 32'd100);       // exact
    send_request(REQ_REMOVE, key_pool[1], 32'd0);
    send_request(REQ_REMOVE, key_pool[3], 32'd7);         // missing
    send_request(REQ_QUERY, key_pool[3], 32'hFFFF_FFFF);  // missing
    send_request(REQ_ADD, key_pool[3], 32'hAAAA_5555);
    send_request(REQ_ADD, key_pool[3], 32'h5555_AAAA);    // sums to all ones exactly, no saturation

    // A small table that fills up early.
    run_phase(7'd12, 160, 20);
    // Limit lowered below use, with the long receiver hold-off in it. Drain
    // first so the hold-off lands while requests are still being offered.
    wait_drained();
    hold_off_ask = 1'b1;
    run_phase(7'd3, 120, 24);
    // Full depth with no idling on either side.
    send_idle = 1'b0;
    take_idle = 1'b0;
    run_phase(7'd64, 200, KEY_POOL);
    send_idle = 1'b1;
    take_idle = 1'b1;
    run_phase(7'd127, 200, KEY_POOL);
    run_phase(7'd1, 120, KEY_POOL);
    run_phase(7'd64, 150, KEY_POOL);

    // Let the last responses come back, then watch for strays.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("keyed_count_table_top_tb: PASS");
    end else begin
      $display("keyed_count_table_top_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
design/kct_pkg.sv
design/kct_if.sv
design/kct_front.sv
design/kct_fifo.sv
design/kct_back.sv
design/keyed_count_table_top.sv
tb/keyed_count_table_ledger.sv
tb/keyed_count_table_top_tb.sv
